// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the segment bit unpacker RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBU_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbu assertion failed");

// Next-cycle implication, disabled during reset.
`define SBU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbu assertion failed");

`endif

// File: hw/rtl/sbu_pkg.sv
// Shared constants and types for the segment bit unpacker.
// No dependencies; imported by every sbu module.
package sbu_pkg;

  localparam int WORD_BITS   = 32;
  localparam int COUNT_BITS  = 8;
  localparam int CODE_BITS   = 3;
  localparam int PIXEL_BITS  = 8;
  localparam int MAX_RESULTS = 32;
  // at most 7 bits are carried between words
  localparam int CARRY_BITS  = 7;
  localparam int ACC_BITS    = WORD_BITS + CARRY_BITS;
  localparam int AVAIL_BITS  = $clog2(ACC_BITS + 1);
  localparam int NRES_BITS   = $clog2(MAX_RESULTS + 1);
  localparam int NEED_BITS   = $clog2(PIXEL_BITS + 1);
  localparam int WIDTH_CODE_BITS = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // back end status seen by the front end
  typedef struct packed {
    logic finished;
  } back_status_t;

endpackage

// File: hw/rtl/sbu_front.sv
// Input stage of the segment bit unpacker: registers incoming words.
// Depends on sbu_pkg; drops words once the stream has ended.
module sbu_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         word_valid,
  output logic                         word_ready,
  input  logic [sbu_pkg::WORD_BITS-1:0] code_word,
  input  sbu_pkg::back_status_t        status,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic [sbu_pkg::WORD_BITS-1:0] q_word
);
  import sbu_pkg::*;

  logic                 buf_valid;
  logic [WORD_BITS-1:0] buf_word;
  logic                 consume;

  // after end of stream, items are taken and discarded here
  assign consume    = buf_valid & (q_ready | status.finished);
  assign q_valid    = buf_valid & ~status.finished;
  assign q_word     = buf_word;
  assign word_ready = ~buf_valid | consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (word_ready) begin
      buf_valid <= word_valid;
    end
    if (word_valid && word_ready) begin
      buf_word <= code_word;
    end
  end

endmodule

// File: hw/rtl/sbu_queue.sv
// Small word queue between the front and back ends of the unpacker.
// Depends on sbu_pkg for depth and word width.
`include "assert_macros.svh"

module sbu_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push_valid,
  output logic                         push_ready,
  input  logic [sbu_pkg::WORD_BITS-1:0] push_word,
  output logic                         pop_valid,
  input  logic                         pop_ready,
  output logic [sbu_pkg::WORD_BITS-1:0] pop_word
);
  import sbu_pkg::*;

  logic [WORD_BITS-1:0]   mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCOUNT_BITS-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QCOUNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = mem[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  `SBU_ASSERT(a_count_bound, clk, rst, 1'b1, count <= QCOUNT_BITS'(QUEUE_DEPTH))
  `SBU_ASSERT_NEXT(a_full_no_grow, clk, rst, !push_ready && !do_pop, !push_ready)

endmodule

// File: hw/rtl/sbu_back.sv
// Back end of the unpacker: walks the bit stream one field per cycle unless the output stalls.
// Depends on sbu_pkg; holds one result back to tag the last of each word.
`include "assert_macros.svh"

module sbu_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [sbu_pkg::WORD_BITS-1:0]  q_word,
  output sbu_pkg::back_status_t         status,
  output logic                          pixel_valid,
  input  logic                          pixel_ready,
  output logic [sbu_pkg::PIXEL_BITS-1:0] pixel,
  output logic                          end_of_stream,
  output logic                          last
);
  import sbu_pkg::*;

  typedef enum logic [1:0] {PH_COUNT, PH_CODE, PH_PIX} phase_t;

  phase_t                  phase;
  logic                    have_word;
  logic [ACC_BITS-1:0]     acc;       // valid bits left-aligned, zeros below
  logic [AVAIL_BITS-1:0]   avail;
  logic [NRES_BITS-1:0]    nres;
  logic [COUNT_BITS-1:0]   pixels_left;
  logic [NEED_BITS-1:0]    pixel_width;
  logic                    finished;
  logic                    pend_valid;
  logic [PIXEL_BITS-1:0]   pend_pixel;
  logic                    pend_eos;

  logic [NEED_BITS-1:0]    need;
  logic [PIXEL_BITS-1:0]   field;
  logic                    out_free;
  logic                    word_done;
  logic                    step;
  logic                    is_result;
  logic                    stall;
  logic                    load;
  logic [PIXEL_BITS-1:0]   res_pixel;
  logic                    res_eos;

  always_comb begin
    case (phase)
      PH_PIX:  need = pixel_width;
      PH_CODE: need = NEED_BITS'(CODE_BITS);
      default: need = NEED_BITS'(COUNT_BITS);
    endcase
  end

  assign field     = acc[ACC_BITS-1 -: PIXEL_BITS] >> (NEED_BITS'(PIXEL_BITS) - need);
  assign out_free  = ~pixel_valid | pixel_ready;
  assign word_done = have_word &
                     ((avail < AVAIL_BITS'(need)) | (nres == NRES_BITS'(MAX_RESULTS)));
  assign step      = have_word & ~word_done;
  assign is_result = step & ((phase == PH_PIX) | ((phase == PH_COUNT) & (field == '0)));
  assign res_eos   = (phase != PH_PIX);
  assign res_pixel = res_eos ? '0 : field;
  assign stall     = pend_valid & ~out_free & (word_done | is_result);
  // words popped after the end of stream are discarded
  assign q_ready   = ~have_word;
  assign load      = q_valid & ~have_word & ~finished;
  assign status.finished = finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_COUNT;
      have_word   <= 1'b0;
      acc         <= '0;
      avail       <= '0;
      nres        <= '0;
      pixels_left <= '0;
      pixel_width <= NEED_BITS'(PIXEL_BITS);
      finished    <= 1'b0;
      pend_valid  <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end

      if (load) begin
        acc       <= acc | ({q_word, CARRY_BITS'(0)} >> avail[2:0]);
        avail     <= avail + AVAIL_BITS'(WORD_BITS);
        nres      <= '0;
        have_word <= 1'b1;
      end else if (have_word && !stall) begin
        if (word_done) begin
          have_word <= 1'b0;
          if (pend_valid) begin
            pixel_valid   <= 1'b1;
            pixel         <= pend_pixel;
            end_of_stream <= pend_eos;
            last          <= 1'b1;
            pend_valid    <= 1'b0;
          end
        end else begin
          acc   <= acc << need;
          avail <= avail - AVAIL_BITS'(need);
          case (phase)
            PH_PIX: begin
              pixels_left <= pixels_left - 1'b1;
              if (pixels_left == COUNT_BITS'(1)) begin
                phase <= PH_COUNT;
              end
            end
            PH_CODE: begin
              pixel_width <= (field[WIDTH_CODE_BITS-1:0] == '0) ?
                             NEED_BITS'(PIXEL_BITS) : NEED_BITS'(field[WIDTH_CODE_BITS-1:0]);
              phase <= PH_PIX;
            end
            default: begin
              if (field == '0) begin
                // zero count: end of stream, rest of the word is dropped
                finished <= 1'b1;
                avail    <= '0;
                acc      <= '0;
              end else begin
                pixels_left <= field;
                phase       <= PH_CODE;
              end
            end
          endcase

          if (is_result) begin
            if (pend_valid) begin
              pixel_valid   <= 1'b1;
              pixel         <= pend_pixel;
              end_of_stream <= pend_eos;
              last          <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_pixel <= res_pixel;
            pend_eos   <= res_eos;
            nres       <= nres + 1'b1;
          end
        end
      end
    end
  end

  `SBU_ASSERT(a_carry_bound, clk, rst, !have_word, avail <= AVAIL_BITS'(CARRY_BITS))
  `SBU_ASSERT(a_eos_is_last, clk, rst, pixel_valid && end_of_stream, last)
  `SBU_ASSERT_NEXT(a_finished_idle, clk, rst, finished && !have_word, !have_word && !pend_valid)

endmodule

// File: hw/rtl/segment_bit_unpacker.sv
// Segment bit unpacker: decodes a packed stream of segment-coded pixels.
// Channels: word_valid/word_ready with code_word (32 bits, read MSB first);
// pixel_valid/pixel_ready with pixel, end_of_stream and last.
// Each segment is an 8-bit pixel count, a 3-bit width code (0 means 8) and
// that many pixels, each sent zero-extended to 8 bits. Fields may cross
// word boundaries. A zero count yields one item with end_of_stream set
// and ends the stream; later words are accepted and dropped.
// last marks the final item caused by an input word; a word that causes
// no item (only padding or a partial field) produces nothing.
// Throughput: the back end consumes one field per cycle while the output
// does not stall, plus a load step and a wrap-up step per word; it takes
// no new word until the last one is wrapped up. The input register and a
// two-word queue keep words flowing while the back end works.
// Output path: each pixel is held one item behind the decoder (it is held
// until the next item or the end of its word shows whether it is last), and
// a word passes the input register and the queue before the decoder loads it.
// Reset (rst, synchronous) clears the carry, the segment state and all
// queues. When the receiver stalls, the output register and held item
// fill and the decoder waits; words still collect in the queue.
module segment_bit_unpacker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          word_valid,
  output logic                          word_ready,
  input  logic [sbu_pkg::WORD_BITS-1:0]  code_word,
  output logic                          pixel_valid,
  input  logic                          pixel_ready,
  output logic [sbu_pkg::PIXEL_BITS-1:0] pixel,
  output logic                          end_of_stream,
  output logic                          last
);
  import sbu_pkg::*;

  back_status_t         status;
  logic                 f_valid;
  logic                 f_ready;
  logic [WORD_BITS-1:0] f_word;
  logic                 q_valid;
  logic                 q_ready;
  logic [WORD_BITS-1:0] q_word;

  sbu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .code_word  (code_word),
    .status     (status),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_word     (f_word)
  );

  sbu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_word  (f_word),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_word   (q_word)
  );

  sbu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_word        (q_word),
    .status        (status),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel         (pixel),
    .end_of_stream (end_of_stream),
    .last          (last)
  );

endmodule
